// ----- rtl/bmprgba_pkg.sv -----
// Shared constants for the BMP byte stream to RGBA pixel decoder.
`timescale 1ns / 1ps
`default_nettype none
package bmprgba_pkg;

  // Header and palette geometry
  localparam int HEADER_BYTES    = 54;
  localparam int PALETTE_ENTRIES = 256;
  localparam int POS_W           = 10;
  localparam int PAL_W           = 24;
  localparam int PAL_AW          = 8;
  localparam int DIM_W           = 14;

  localparam logic [POS_W-1:0] HDR_LAST = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] PAL_LAST = POS_W'(PALETTE_ENTRIES * 4 - 1);

  // Header field offsets
  localparam logic [POS_W-1:0] OFS_SIG0    = POS_W'(8'h00);
  localparam logic [POS_W-1:0] OFS_SIG1    = POS_W'(8'h01);
  localparam logic [POS_W-1:0] OFS_WIDTH0  = POS_W'(8'h12);
  localparam logic [POS_W-1:0] OFS_WIDTH1  = POS_W'(8'h13);
  localparam logic [POS_W-1:0] OFS_WIDTH2  = POS_W'(8'h14);
  localparam logic [POS_W-1:0] OFS_WIDTH3  = POS_W'(8'h15);
  localparam logic [POS_W-1:0] OFS_HEIGHT0 = POS_W'(8'h16);
  localparam logic [POS_W-1:0] OFS_HEIGHT1 = POS_W'(8'h17);
  localparam logic [POS_W-1:0] OFS_HEIGHT2 = POS_W'(8'h18);
  localparam logic [POS_W-1:0] OFS_HEIGHT3 = POS_W'(8'h19);
  localparam logic [POS_W-1:0] OFS_BPP0    = POS_W'(8'h1C);
  localparam logic [POS_W-1:0] OFS_BPP1    = POS_W'(8'h1D);

  // Signature bytes and supported depths
  localparam logic [7:0]  SIG_B  = 8'h42;
  localparam logic [7:0]  SIG_M  = 8'h4D;
  localparam logic [15:0] BPP_8  = 16'd8;
  localparam logic [15:0] BPP_24 = 16'd24;
  localparam logic [15:0] BPP_32 = 16'd32;
  localparam logic [7:0]  BYTE_FULL = 8'hFF;

endpackage
`default_nettype wire

// ----- rtl/bmprgba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bmprgba_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, then registered read that holds when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/bmp_pixel_stream_to_rgba_top.sv -----
// Streaming BMP decoder: one file byte per item in, RGBA pixel items out.
// Latency: a result item appears on out_* the cycle after the byte that completes it.
// Throughput: one byte per cycle unless out_ready stalls; palette RAM read is pipelined.
// The output register frees in_ready whenever it is empty or being taken.
// Reset (sync, active low) puts the parser at byte 0 of the header with all counters clear.
// Palette RAM contents are undefined until loaded; no clearing pass is run.
`timescale 1ns / 1ps
`default_nettype none
module bmp_pixel_stream_to_rgba_top #(
  parameter int MAX_DIM = 8192
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_first_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_red,
  output logic      [7:0] out_green,
  output logic      [7:0] out_blue,
  output logic      [7:0] out_alpha,
  output logic            out_last_pixel,
  output logic            out_header_error
);
  import bmprgba_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PALETTE,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  localparam logic [DIM_W-1:0] MAX_DIM_C = DIM_W'(MAX_DIM);

  // Parser state
  phase_t             phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [DIM_W-1:0]   width_r, width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic [15:0]        bpp_r, bpp_nxt;
  logic [DIM_W-1:0]   col_r, col_nxt;
  logic [DIM_W-1:0]   row_r, row_nxt;
  logic [1:0]         lane_r, lane_nxt;
  logic [1:0]         pad_r, pad_nxt;
  logic [PAL_W-1:0]   asm_r, asm_nxt;
  logic               fault_r, fault_nxt;

  // Output stage
  logic               out_valid_r;
  logic [7:0]         out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic               out_last_r, out_err_r, out_pal_r;

  // Result of the current byte
  logic               emit_c, last_c, err_c, pal_c;
  logic [7:0]         red_c, green_c, blue_c, alpha_c;

  logic               acc;
  logic               last_col, last_row, bad_hdr;
  logic [1:0]         row_pad;
  logic               pal_we;
  logic [PAL_W-1:0]   pal_rdata;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;

  assign last_col = ({1'b0, col_r} + 15'd1) >= {1'b0, width_r};
  assign last_row = ({1'b0, row_r} + 15'd1) >= {1'b0, height_r};

  // Row padding to a 4-byte boundary
  always_comb begin
    if (bpp_r == BPP_8) begin
      row_pad = 2'(2'd0 - width_r[1:0]);
    end else if (bpp_r == BPP_24) begin
      row_pad = width_r[1:0];
    end else begin
      row_pad = 2'd0;
    end
  end

  // Next state and result of one accepted byte
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    bpp_nxt    = bpp_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    lane_nxt   = lane_r;
    pad_nxt    = pad_r;
    asm_nxt    = asm_r;
    fault_nxt  = fault_r;
    emit_c     = 1'b0;
    last_c     = 1'b0;
    err_c      = 1'b0;
    pal_c      = 1'b0;
    red_c      = 8'd0;
    green_c    = 8'd0;
    blue_c     = 8'd0;
    alpha_c    = 8'd0;
    bad_hdr    = 1'b0;
    pal_we     = 1'b0;

    if (acc) begin
      // Restart the parser on a file mark
      if (in_first_byte) begin
        phase_nxt  = PH_HEADER;
        pos_nxt    = '0;
        width_nxt  = '0;
        height_nxt = '0;
        bpp_nxt    = '0;
        fault_nxt  = 1'b0;
      end

      case (phase_nxt)
        PH_HEADER: begin
          unique case (pos_nxt) inside
            OFS_SIG0:    if (in_data_byte != SIG_B) fault_nxt = 1'b1;
            OFS_SIG1:    if (in_data_byte != SIG_M) fault_nxt = 1'b1;
            OFS_WIDTH0:  width_nxt = DIM_W'(in_data_byte);
            OFS_WIDTH1: begin
              width_nxt = width_nxt | {in_data_byte[5:0], 8'd0};
              if (in_data_byte[7:6] != 2'd0) fault_nxt = 1'b1;
            end
            OFS_HEIGHT0: height_nxt = DIM_W'(in_data_byte);
            OFS_HEIGHT1: begin
              height_nxt = height_nxt | {in_data_byte[5:0], 8'd0};
              if (in_data_byte[7:6] != 2'd0) fault_nxt = 1'b1;
            end
            OFS_WIDTH2, OFS_WIDTH3, OFS_HEIGHT2, OFS_HEIGHT3: begin
              if (in_data_byte != 8'd0) fault_nxt = 1'b1;
            end
            OFS_BPP0:    bpp_nxt = 16'(in_data_byte);
            OFS_BPP1:    bpp_nxt = bpp_nxt | {in_data_byte, 8'd0};
            default: ;
          endcase

          if (pos_nxt >= HDR_LAST) begin
            bad_hdr = fault_nxt ||
                      (bpp_nxt != BPP_8 && bpp_nxt != BPP_24 && bpp_nxt != BPP_32) ||
                      width_nxt > MAX_DIM_C || height_nxt > MAX_DIM_C;
            pos_nxt = '0;
            if (bad_hdr) begin
              phase_nxt = PH_DONE;
              emit_c    = 1'b1;
              err_c     = 1'b1;
            end else if (bpp_nxt == BPP_8) begin
              phase_nxt = PH_PALETTE;
              asm_nxt   = '0;
            end else begin
              col_nxt   = '0;
              row_nxt   = '0;
              lane_nxt  = '0;
              pad_nxt   = '0;
              asm_nxt   = '0;
              phase_nxt = (width_nxt == '0 || height_nxt == '0) ? PH_DONE : PH_PIXELS;
            end
          end else begin
            pos_nxt = pos_nxt + POS_W'(1);
          end
        end

        PH_PALETTE: begin
          // Gather B, G, R then store the entry on the fourth byte
          case (pos_r[1:0])
            2'd0:    asm_nxt = PAL_W'(in_data_byte);
            2'd1:    asm_nxt[15:8] = in_data_byte;
            2'd2:    asm_nxt[23:16] = in_data_byte;
            default: pal_we = 1'b1;
          endcase
          if (pos_r >= PAL_LAST) begin
            pos_nxt   = '0;
            col_nxt   = '0;
            row_nxt   = '0;
            lane_nxt  = '0;
            pad_nxt   = '0;
            asm_nxt   = '0;
            phase_nxt = (width_r == '0 || height_r == '0) ? PH_DONE : PH_PIXELS;
          end else begin
            pos_nxt = pos_r + POS_W'(1);
          end
        end

        PH_PIXELS: begin
          if (pad_r != 2'd0) begin
            // Drop a padding byte
            pad_nxt = pad_r - 2'd1;
          end else begin
            if (bpp_r == BPP_8) begin
              emit_c = 1'b1;
              pal_c  = 1'b1;
            end else if (bpp_r == BPP_24) begin
              if (lane_r < 2'd2) begin
                if (lane_r == 2'd0) asm_nxt[7:0] = in_data_byte;
                else                asm_nxt[15:8] = in_data_byte;
                lane_nxt = lane_r + 2'd1;
              end else begin
                emit_c  = 1'b1;
                red_c   = in_data_byte;
                green_c = asm_r[15:8];
                blue_c  = asm_r[7:0];
              end
            end else begin
              if (lane_r < 2'd3) begin
                case (lane_r)
                  2'd0:    asm_nxt[7:0]   = in_data_byte;
                  2'd1:    asm_nxt[15:8]  = in_data_byte;
                  default: asm_nxt[23:16] = in_data_byte;
                endcase
                lane_nxt = lane_r + 2'd1;
              end else begin
                emit_c  = 1'b1;
                red_c   = in_data_byte;
                green_c = asm_r[15:8];
                blue_c  = asm_r[23:16];
              end
            end

            // Finish a pixel: advance column and row
            if (emit_c) begin
              last_c   = last_col && last_row;
              alpha_c  = (bpp_r == BPP_32 && in_data_byte == BYTE_FULL &&
                          asm_r[15:8] == BYTE_FULL && asm_r[23:16] == BYTE_FULL) ?
                         8'd0 : BYTE_FULL;
              lane_nxt = '0;
              asm_nxt  = '0;
              if (last_col) begin
                if (last_row) begin
                  phase_nxt = PH_DONE;
                end else begin
                  col_nxt = '0;
                  row_nxt = row_r + DIM_W'(1);
                  pad_nxt = row_pad;
                end
              end else begin
                col_nxt = col_r + DIM_W'(1);
              end
            end
          end
        end

        default: ;
      endcase
    end
  end

  // Palette store: written during the palette phase, read by 8 bpp pixels
  bmprgba_ram #(
    .WIDTH (PAL_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pos_r[POS_W-1:2]),
    .wdata (asm_r),
    .re    (emit_c && pal_c),
    .raddr (in_data_byte),
    .rdata (pal_rdata)
  );

  // Hold parser state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= '0;
      width_r     <= '0;
      height_r    <= '0;
      bpp_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      lane_r      <= '0;
      pad_r       <= '0;
      asm_r       <= '0;
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bpp_r    <= bpp_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      lane_r   <= lane_nxt;
      pad_r    <= pad_nxt;
      asm_r    <= asm_nxt;
      fault_r  <= fault_nxt;
      if (acc) begin
        out_valid_r <= emit_c;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (acc && emit_c) begin
      out_red_r   <= red_c;
      out_green_r <= green_c;
      out_blue_r  <= blue_c;
      out_alpha_r <= alpha_c;
      out_last_r  <= last_c;
      out_err_r   <= err_c;
      out_pal_r   <= pal_c;
    end
  end

  // Palette pixels take their color from the RAM read data
  assign out_valid        = out_valid_r;
  assign out_red          = out_pal_r ? pal_rdata[23:16] : out_red_r;
  assign out_green        = out_pal_r ? pal_rdata[15:8]  : out_green_r;
  assign out_blue         = out_pal_r ? pal_rdata[7:0]   : out_blue_r;
  assign out_alpha        = out_pal_r ? BYTE_FULL        : out_alpha_r;
  assign out_last_pixel   = out_last_r;
  assign out_header_error = out_err_r;

  // Counters stay inside the image while pixels stream
  a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PIXELS |-> (col_r < width_r) && (row_r < height_r))
    else $error("pixel position outside image");

  // A 24 bpp pixel completes on its third byte
  a_lane_24: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PIXELS && bpp_r == BPP_24) |-> lane_r != 2'd3)
    else $error("24 bpp byte lane overran");

  // The last pixel closes the image
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit_c && last_c) |=> phase_r == PH_DONE)
    else $error("parser not done after last pixel");

  // An error item carries no pixel
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (!out_pal_r && out_red_r == 8'd0 &&
      out_alpha_r == 8'd0 && !out_last_r))
    else $error("error item with pixel data");

endmodule
`default_nettype wire
